// ----- rtl/core/sbda_pkg.sv -----
// Shared constants for the signed binary to decimal ASCII converter.
// Used by the BCD digit cell and the top level; depends on nothing.

package sbda_pkg;

    // Input word and BCD digit chain sizes.
    localparam int IN_W      = 32;
    localparam int DIGITS    = 10;
    localparam int DIGIT_W   = 4;
    localparam int CNT_W     = $clog2(IN_W);
    localparam int LEFT_W    = $clog2(DIGITS + 1);

    // Output character width and the character codes for zero, minus and nine.
    localparam int               CHAR_W     = 6;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;

    // Operations driven into every digit cell.
    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_DABBLE = 2'd2;
    localparam logic [1:0] OP_MOVE   = 2'd3;

    typedef logic [DIGIT_W-1:0] t_digit;

endpackage

// ----- rtl/core/sbda_bcd_cell.sv -----
// One BCD digit cell of the double-dabble chain.
// Depends on sbda_pkg for the digit type and the cell operation codes.

module sbda_bcd_cell (
    input  logic              i_clk,
    input  logic [1:0]        i_op,
    input  logic              i_carry,
    output logic              o_carry,
    input  sbda_pkg::t_digit  i_digit,
    output sbda_pkg::t_digit  o_digit
);

    sbda_pkg::t_digit r_digit;
    sbda_pkg::t_digit n_digit;
    sbda_pkg::t_digit w_adj;

    // Add three to digits of five and up before the shift, so the doubled
    // value carries correctly into the next decade.
    always_comb begin
        w_adj   = (r_digit >= 4'd5) ? r_digit + 4'd3 : r_digit;
        o_carry = w_adj[3];
        unique case (i_op)
            sbda_pkg::OP_CLEAR:  n_digit = '0;
            sbda_pkg::OP_DABBLE: n_digit = {w_adj[2:0], i_carry};
            sbda_pkg::OP_MOVE:   n_digit = i_digit;
            default:             n_digit = r_digit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_digit = r_digit;

endmodule

// ----- rtl/core/signed_binary_to_decimal_ascii.sv -----
// Signed 32-bit integer to decimal ASCII text converter, top level.
// Depends on sbda_pkg and instantiates a chain of sbda_bcd_cell digit cells.
//
//   Channel   Dir   Signals                      Contents
//   s_axis    in    tvalid tready tdata[31:0]    value (signed, two's complement)
//   m_axis    out   tvalid tready tdata[7:0]     character in bits 5:0, zeros above
//                   tlast                        last character of the number
//
// A number is accepted, converted by double-dabble through the ten-cell
// digit chain, then each digit position is either dropped as a leading zero
// or sent as a character; the sequencer leaves the zero-skipping phase
// before the first digit is sent, and a negative number is sent with a
// leading minus sign.
// Reset (synchronous, active low) returns the sequencer to idle and empties
// the output register. A stalled output holds its word and the sequencer
// waits; a new number is taken only once the previous one is fully handed
// to the output register.

module signed_binary_to_decimal_ascii (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [5:0] character, [7:6] zero
    output logic        m_axis_tlast
);

    localparam int DIGITS  = sbda_pkg::DIGITS;
    localparam int IN_W    = sbda_pkg::IN_W;
    localparam int CNT_W   = sbda_pkg::CNT_W;
    localparam int LEFT_W  = sbda_pkg::LEFT_W;
    localparam int CHAR_W  = sbda_pkg::CHAR_W;

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_SKIP = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [IN_W-1:0]   r_mag;
    logic [IN_W-1:0]   n_mag;
    logic              r_neg;
    logic              n_neg;
    logic              r_sign_pend;
    logic              n_sign_pend;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic [LEFT_W-1:0] r_left;
    logic [LEFT_W-1:0] n_left;

    logic              r_out_valid;
    logic              n_out_valid;
    logic [CHAR_W-1:0] r_out_char;
    logic [CHAR_W-1:0] n_out_char;
    logic              r_out_last;
    logic              n_out_last;

    logic              w_accept;
    logic              w_out_free;
    logic              w_in_neg;
    logic [1:0]        w_op;
    sbda_pkg::t_digit  w_top;
    sbda_pkg::t_digit  w_digit [DIGITS];
    logic              w_carry [DIGITS];

    // Digit chain: cell 0 is the units digit and takes the magnitude's MSB
    // during conversion; during output the digits move one cell up per step
    // so the most significant digit always sits in the top cell.
    for (genvar g = 0; g < DIGITS; g++) begin : g_cell
        if (g == 0) begin : g_first
            sbda_bcd_cell u_cell (
                .i_clk   (i_clk),
                .i_op    (w_op),
                .i_carry (r_mag[IN_W-1]),
                .o_carry (w_carry[g]),
                .i_digit ('0),
                .o_digit (w_digit[g])
            );
        end else begin : g_rest
            sbda_bcd_cell u_cell (
                .i_clk   (i_clk),
                .i_op    (w_op),
                .i_carry (w_carry[g-1]),
                .o_carry (w_carry[g]),
                .i_digit (w_digit[g-1]),
                .o_digit (w_digit[g])
            );
        end
    end

    assign w_top         = w_digit[DIGITS-1];
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_in_neg      = s_axis_tdata[IN_W-1];

    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_sign_pend = r_sign_pend;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        w_op        = sbda_pkg::OP_HOLD;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    // Negation on 32 bits gives the exact magnitude of the
                    // most negative value as an unsigned number.
                    n_mag   = w_in_neg ? (~s_axis_tdata + 32'd1) : s_axis_tdata;
                    n_neg   = w_in_neg;
                    n_cnt   = '0;
                    w_op    = sbda_pkg::OP_CLEAR;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                w_op  = sbda_pkg::OP_DABBLE;
                n_mag = {r_mag[IN_W-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(IN_W - 1)) begin
                    n_left  = LEFT_W'(DIGITS);
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                // Drop leading zeros but always keep the units digit.
                if (w_top == '0 && r_left != LEFT_W'(1)) begin
                    w_op   = sbda_pkg::OP_MOVE;
                    n_left = r_left - 1'b1;
                end else begin
                    n_sign_pend = r_neg;
                    n_state     = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (r_sign_pend) begin
                        n_out_char  = sbda_pkg::CHAR_MINUS;
                        n_out_last  = 1'b0;
                        n_sign_pend = 1'b0;
                    end else begin
                        n_out_char = sbda_pkg::CHAR_ZERO + {2'b00, w_top};
                        n_out_last = (r_left == LEFT_W'(1));
                        w_op       = sbda_pkg::OP_MOVE;
                        n_left     = r_left - 1'b1;
                        if (r_left == LEFT_W'(1)) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_sign_pend <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_sign_pend <= n_sign_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag      <= n_mag;
        r_neg      <= n_neg;
        r_cnt      <= n_cnt;
        r_left     <= n_left;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_char};
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    // A 32-bit magnitude fits in ten decimal digits, so the top cell never
    // carries out of the chain.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV) |-> !w_carry[DIGITS-1])
        else $error("digit chain overflow during conversion");

    // While characters are being sent at least the units digit remains.
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_left != '0))
        else $error("emit state with no digits left");

    // Every character shown is the minus sign or a decimal digit.
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_out_char == sbda_pkg::CHAR_MINUS ||
                           (r_out_char >= sbda_pkg::CHAR_ZERO &&
                            r_out_char <= sbda_pkg::CHAR_NINE)))
        else $error("character out of range");

    // The minus sign is never the last character of a number.
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out_char == sbda_pkg::CHAR_MINUS) |-> !m_axis_tlast)
        else $error("minus sign flagged as last");
`endif

endmodule

// ----- bench/tb_signed_binary_to_decimal_ascii.sv -----
// Self-checking testbench for the signed binary to decimal ASCII converter.
// Needs signed_binary_to_decimal_ascii, sbda_bcd_cell and sbda_pkg; uses the package constants.

module tb_signed_binary_to_decimal_ascii;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles to wait after the last expected word before a pause is over. The
    // block takes less than this per number when the receiver does not stall,
    // so this covers any word a broken design might still push out.
    localparam int DRAIN_TAIL = 64;

    // One output word as the converter should present it.
    typedef struct packed {
        logic [sbda_pkg::CHAR_W-1:0] code;
        logic                        last;
    } t_char_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;    // [31:0] value
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [5:0] character, [7:6] zero
    logic        m_axis_tlast;

    // Characters still owed by the block, oldest first.
    t_char_word expected_chars[$];
    int         mismatch_count = 0;

    // A nonzero value asks the receiver to refuse words for that many cycles.
    int         holdoff_request = 0;

    signed_binary_to_decimal_ascii i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on the run. The slowest correct run (every number eleven
    // characters, the receiver mostly stalled) is well under 3 ms, so the limit
    // leaves a wide margin.
    initial begin
        #3ms;
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Works out the decimal text of a value and queues it, one word per
    // character. The magnitude is taken as an unsigned 32-bit negation, so the
    // most negative value still yields "-2147483648".
    function automatic void push_decimal_text(logic [31:0] value);
        logic [31:0] magnitude;
        logic [3:0]  digit_buf [10];
        int          count;
        t_char_word  w;
        magnitude = value[31] ? (~value + 32'd1) : value;
        count = 0;
        do begin
            digit_buf[count] = 4'(magnitude % 32'd10);
            magnitude = magnitude / 32'd10;
            count++;
        end while (magnitude != 0 && count < 10);
        if (value[31]) begin
            w.code = sbda_pkg::CHAR_MINUS;
            w.last = 1'b0;
            expected_chars.push_back(w);
        end
        for (int k = count - 1; k >= 0; k--) begin
            w.code = sbda_pkg::CHAR_ZERO + sbda_pkg::CHAR_W'(digit_buf[k]);
            w.last = (k == 0);
            expected_chars.push_back(w);
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic check_char_word(input logic [7:0] data, input logic last);
        t_char_word want;
        if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("word %h last %b with nothing expected", data, last));
            return;
        end
        want = expected_chars.pop_front();
        if (data[sbda_pkg::CHAR_W-1:0] !== want.code) begin
            report_mismatch($sformatf("character %0d, expected %0d",
                                      data[sbda_pkg::CHAR_W-1:0], want.code));
        end
        if (data[7:sbda_pkg::CHAR_W] !== '0) begin
            report_mismatch($sformatf("padding bits %b not zero",
                                      data[7:sbda_pkg::CHAR_W]));
        end
        if (last !== want.last) begin
            report_mismatch($sformatf("last flag %b, expected %b", last, want.last));
        end
    endtask

    // Both handshakes are sampled at the rising edge, where every input still
    // holds the value driven on the previous edge. An accepted number is
    // predicted before any output word of the same edge is checked; the block
    // cannot answer a number on the edge that accepts it anyway.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            push_decimal_text(s_axis_tdata);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            check_char_word(m_axis_tdata, m_axis_tlast);
        end
    end

    // ------------------------------------------------------------------
    // Receiver
    // ------------------------------------------------------------------

    // The receiver follows a 16-bit ready pattern that is redrawn after every
    // fourth pass: sometimes all ones (no stalls at all), sometimes mostly ready,
    // sometimes mostly stalled, sometimes plain random. A hold-off request
    // overrides the pattern and is counted down here, cycle by cycle.
    always @(posedge i_clk) begin
        static int          holdoff_left = 0;
        static int          phase = 0;
        static logic [15:0] ready_pattern = '1;
        if (holdoff_request != 0) begin
            holdoff_left = holdoff_request;
            holdoff_request = 0;
        end
        if (phase == 0) begin
            case ($urandom_range(3))
                0: ready_pattern = '1;
                1: ready_pattern = 16'($urandom()) | 16'($urandom());
                2: ready_pattern = 16'($urandom()) & 16'($urandom());
                default: ready_pattern = 16'($urandom());
            endcase
        end
        if (holdoff_left > 0) begin
            m_axis_tready <= 1'b0;
            holdoff_left--;
        end else begin
            m_axis_tready <= ready_pattern[phase % 16];
        end
        phase = (phase + 1) % 64;
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offers one number and returns on the edge that accepts it. The valid
    // stays high afterwards so that back-to-back calls form a burst.
    task automatic send_value(input logic [31:0] value);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Drops the valid for a gap of the given number of cycles; junk on the
    // data bus must be ignored while valid is low.
    task automatic idle_input(input int cycles);
        if (cycles > 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom();
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Stops sending and waits until every predicted character has come out,
    // then a little longer to catch anything extra.
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    // Draws a value: plain random words, small numbers around zero, numbers of
    // a chosen digit count, values next to powers of ten, the two ends of the
    // range, and powers of two.
    function automatic logic [31:0] pick_value();
        longint lo;
        longint hi;
        longint mag;
        int     digits;
        mag = 0;
        case ($urandom_range(5))
            0: mag = longint'($urandom());
            1: mag = longint'($urandom_range(40)) - 20;
            2: begin
                digits = $urandom_range(1, 10);
                lo = 1;
                repeat (digits - 1) lo = lo * 10;
                hi = lo * 10 - 1;
                if (hi > 64'sd2147483647) begin
                    hi = 64'sd2147483647;
                end
                mag = lo + longint'($urandom_range(32'(hi - lo)));
                if (digits == 1) begin
                    mag = longint'($urandom_range(9));
                end
                if ($urandom_range(1) == 1) begin
                    mag = -mag;
                end
            end
            3: begin
                lo = 1;
                repeat ($urandom_range(9)) lo = lo * 10;
                mag = lo + longint'($urandom_range(2)) - 1;
                if ($urandom_range(1) == 1) begin
                    mag = -mag;
                end
            end
            4: mag = ($urandom_range(1) == 1) ? 64'sd2147483647 : -64'sd2147483648;
            default: mag = longint'(32'd1 << $urandom_range(31));
        endcase
        return 32'(mag);
    endfunction

    // Sends a run of random numbers in bursts of random length, with random
    // gaps between the bursts, some of them zero so valid never drops.
    task automatic send_random_bursts(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 8);
            for (int b = 0; b < burst && sent < count; b++) begin
                send_value(pick_value());
                sent++;
            end
            if ($urandom_range(3) != 0) begin
                idle_input($urandom_range(1, 60));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Zero, single digits, two, three, nine and ten digits, both signs, the
    // largest value, the most negative value and its neighbor, alternating bits.
    task automatic test_corner_values();
        int corner_values[$];
        corner_values = '{0, 1, -1, 7, -7, 9, 10, -10, 100, 999999999, 1000000000,
                          -999999999, -1000000000, 123456789, -987654321,
                          2147483647, -2147483647, -2147483647 - 1,
                          1431655765, -1431655766, 2000000000};
        foreach (corner_values[i]) begin
            send_value(32'(corner_values[i]));
        end
        wait_for_drain();
    endtask

    // The receiver refuses words for a long stretch while numbers keep coming,
    // so the block fills up and has to hold its input ready low.
    task automatic test_output_holdoff();
        holdoff_request = 400;
        for (int i = 0; i < 10; i++) begin
            send_value(pick_value());
        end
        wait_for_drain();
    endtask

    // A burst, a full stop until every character is out, then another burst.
    task automatic test_drain_pause();
        send_random_bursts(12);
        wait_for_drain();
        send_random_bursts(12);
        wait_for_drain();
    endtask

    // The bulk of the stimulus.
    task automatic test_random_bursts();
        send_random_bursts(180);
        wait_for_drain();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corner_values();
        test_output_holdoff();
        test_drain_pause();
        test_random_bursts();

        if (expected_chars.size() != 0) begin
            report_mismatch($sformatf("%0d characters never arrived", expected_chars.size()));
        end
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/sbda_pkg.sv
rtl/core/sbda_bcd_cell.sv
rtl/core/signed_binary_to_decimal_ascii.sv
bench/tb_signed_binary_to_decimal_ascii.sv
